/* design/cfh_pkg.sv */
package cfh_pkg;

  // FNV-1 constants
  localparam logic [31:0] HASH_PRIME = 32'h0100_0193;
  localparam logic [31:0] NULL_WORD  = 32'hF0F0_F0F1;
  localparam logic [7:0]  BLANK_BYTE = 8'h20;
  localparam logic [31:0] SEED_RESET = 32'h811C_9DC5;

  // Float minus-zero patterns
  localparam logic [31:0] FLOAT4_NEG_ZERO = 32'h8000_0000;
  localparam logic [63:0] FLOAT8_NEG_ZERO = 64'h8000_0000_0000_0000;

  // Byte counts per column kind
  localparam logic [3:0] CNT_NONE  = 4'd0;
  localparam logic [3:0] CNT_ONE   = 4'd1;
  localparam logic [3:0] CNT_FOUR  = 4'd4;
  localparam logic [3:0] CNT_EIGHT = 4'd8;

  typedef enum logic [1:0] {
    FUNC_DATUM  = 2'd0,
    FUNC_SCALAR = 2'd1,
    FUNC_NULL   = 2'd2,
    FUNC_EMPTY  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_WORD4  = 3'd1,
    KIND_WORD8  = 3'd2,
    KIND_FLOAT4 = 3'd3,
    KIND_FLOAT8 = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MIX  = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

endpackage

/* design/cfh_mix_unit.sv */
module cfh_mix_unit
  import cfh_pkg::*;
(
  input  logic [31:0] hash_in,
  input  logic [7:0]  byte_in,
  output logic [31:0] hash_out
);

  logic [31:0] prod;

  // One FNV-1 round: multiply by prime, then xor the byte
  assign prod     = hash_in * HASH_PRIME;
  assign hash_out = prod ^ {24'd0, byte_in};

endmodule

/* design/chained_fnv1_column_hasher_core.sv */
// Flow: accept the item, then one round per hashed byte (one byte for a datum byte
// or one-byte scalar, four for four-byte scalars and nulls, eight for eight-byte
// scalars and unused kinds, none for an empty datum), then load the output register,
// waiting while it holds an untaken beat. A datum byte that does not end its datum
// skips the load. New items wait for idle; the single multiply-xor unit runs the rounds.
// Reset (synchronous, rst_n low): seed and running hash to 0x811C9DC5, no open datum.
module chained_fnv1_column_hasher_core
  import cfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_data_value,
  input  logic [2:0]  in_scalar_kind,
  input  logic        in_last_of_datum,
  input  logic        in_trim_blanks,
  input  logic        in_end_of_row,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value,
  output logic        out_row_end,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  state_t      state_r, state_nxt;
  logic [31:0] seed_r;
  logic [31:0] running_r;
  logic [31:0] datum_hash_r;
  logic [31:0] kept_hash_r;
  logic        in_datum_r;
  logic [31:0] work_r;
  logic [63:0] data_r;
  logic [3:0]  count_r;
  func_t       func_r;
  logic        first_r;
  logic        last_r;
  logic        trim_r;
  logic        row_end_r;
  logic        out_valid_r;
  logic [31:0] out_hash_r;
  logic        out_row_end_r;

  logic        accept;
  logic        out_free;
  logic        mix_run;
  logic        emit_load;
  logic        final_round;
  logic        datum_open;
  logic [31:0] mix_out;
  logic [31:0] kept_new;
  logic [31:0] start_hash;
  logic [63:0] start_data;
  logic [3:0]  start_count;
  func_t       in_func_e;

  assign in_func_e   = func_t'(in_func);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign final_round = (count_r == CNT_ONE);
  assign datum_open  = (func_r == FUNC_DATUM) && !last_r;

  cfh_mix_unit u_mix (
    .hash_in  (work_r),
    .byte_in  (data_r[7:0]),
    .hash_out (mix_out)
  );

  // Keep hash up to last non-blank byte, or the first byte
  assign kept_new = (first_r || data_r[7:0] != BLANK_BYTE) ? mix_out : kept_hash_r;

  // Preload the working hash, byte stream and round count
  always_comb begin
    start_hash  = running_r;
    start_data  = 64'd0;
    start_count = CNT_NONE;
    unique case (in_func_e)
      FUNC_DATUM: begin
        start_hash  = in_datum_r ? datum_hash_r : running_r;
        start_data  = {56'd0, in_data_value[7:0]};
        start_count = CNT_ONE;
      end
      FUNC_SCALAR: begin
        priority case (in_scalar_kind)
          KIND_BYTE: begin
            start_data  = {56'd0, in_data_value[7:0]};
            start_count = CNT_ONE;
          end
          KIND_WORD4: begin
            start_data  = {32'd0, in_data_value[31:0]};
            start_count = CNT_FOUR;
          end
          KIND_FLOAT4: begin
            start_data  = (in_data_value[31:0] == FLOAT4_NEG_ZERO) ? 64'd0
                                                                   : {32'd0, in_data_value[31:0]};
            start_count = CNT_FOUR;
          end
          KIND_FLOAT8: begin
            start_data  = (in_data_value == FLOAT8_NEG_ZERO) ? 64'd0 : in_data_value;
            start_count = CNT_EIGHT;
          end
          default: begin
            start_data  = in_data_value;
            start_count = CNT_EIGHT;
          end
        endcase
      end
      FUNC_NULL: begin
        start_data  = {32'd0, NULL_WORD};
        start_count = CNT_FOUR;
      end
      FUNC_EMPTY: begin
        start_count = CNT_NONE;
      end
      default: begin
        start_count = CNT_NONE;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (start_count == CNT_NONE) ? ST_EMIT : ST_MIX;
        end
      end
      ST_MIX: begin
        if (final_round) begin
          state_nxt = datum_open ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    mix_run   = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_MIX:  mix_run   = 1'b1;
      ST_EMIT: emit_load = out_free;
      default: in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item and run the rounds
  always_ff @(posedge clk) begin
    if (accept) begin
      work_r    <= start_hash;
      data_r    <= start_data;
      count_r   <= start_count;
      func_r    <= in_func_e;
      first_r   <= !in_datum_r;
      last_r    <= in_last_of_datum;
      trim_r    <= in_trim_blanks;
      row_end_r <= in_end_of_row;
    end else if (mix_run) begin
      count_r <= count_r - 4'd1;
      data_r  <= {8'd0, data_r[63:8]};
      if (final_round && func_r == FUNC_DATUM) begin
        work_r <= trim_r ? kept_new : mix_out;
      end else begin
        work_r <= mix_out;
      end
    end
  end

  // Chain and datum state; seed writes win
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= SEED_RESET;
      running_r    <= SEED_RESET;
      datum_hash_r <= 32'd0;
      kept_hash_r  <= 32'd0;
      in_datum_r   <= 1'b0;
    end else begin
      if (mix_run && final_round && func_r == FUNC_DATUM) begin
        datum_hash_r <= mix_out;
        kept_hash_r  <= kept_new;
        if (!last_r) begin
          in_datum_r <= 1'b1;
        end
      end
      if (emit_load) begin
        running_r  <= row_end_r ? seed_r : work_r;
        in_datum_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        seed_r     <= cfg_wr_data;
        running_r  <= cfg_wr_data;
        in_datum_r <= 1'b0;
      end
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_hash_r    <= work_r;
      out_row_end_r <= row_end_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign out_row_end    = out_row_end_r;

  // Checks
  a_mix_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIX |-> count_r != CNT_NONE)
    else $error("mix round with zero byte count");

  a_empty_emit: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func_e == FUNC_EMPTY |=> state_r == ST_EMIT)
    else $error("empty datum did not go straight to emit");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIX && final_round && !datum_open |=> state_r == ST_EMIT)
    else $error("finished column did not emit");

  a_seed_close: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_datum_r && running_r == seed_r)
    else $error("seed write left datum open or chain unloaded");

  a_emit_beat: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> out_valid_r && out_hash_value == $past(work_r))
    else $error("emitted beat lost");

endmodule

/* test/fnv_column_checker.sv */
`timescale 1ns / 100ps

module fnv_column_checker
  import cfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_data_value,
  input  logic [2:0]  in_scalar_kind,
  input  logic        in_last_of_datum,
  input  logic        in_trim_blanks,
  input  logic        in_end_of_row,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_hash_value,
  input  logic        out_row_end,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic [31:0] hash;
    logic        row_end;
  } column_hash_t;

  column_hash_t expected_hashes[$];

  // Shadow of the hasher state
  logic [31:0] seed_reg;
  logic [31:0] chain_hash;
  logic [31:0] datum_hash;
  logic [31:0] kept_hash;
  logic        datum_open;

  int mismatch_total = 0;
  int result_total   = 0;

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
  end

  // One FNV-1 round: multiply by the prime, then fold in the byte
  function automatic logic [31:0] fnv_round(logic [31:0] h, logic [7:0] b);
    return (h * HASH_PRIME) ^ {24'b0, b};
  endfunction

  // Chain rounds over the low bytes of a word, low byte first
  function automatic logic [31:0] fnv_bytes(logic [31:0] h, logic [63:0] v, logic [3:0] n);
    for (int i = 0; i < n; i++) begin
      h = fnv_round(h, v[8*i +: 8]);
    end
    return h;
  endfunction

  always @(posedge clk) begin : track
    column_hash_t got;
    column_hash_t want;
    logic [31:0]  col_hash;
    logic [63:0]  word;
    logic         produced;

    if (!rst_n) begin
      seed_reg   = SEED_RESET;
      chain_hash = SEED_RESET;
      datum_hash = '0;
      kept_hash  = '0;
      datum_open = 1'b0;
      expected_hashes.delete();
    end else begin
      // Compare the result beat against the oldest prediction
      if (out_valid && out_ready) begin
        got = '{hash: out_hash_value, row_end: out_row_end};
        result_total++;
        if (expected_hashes.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%t: unexpected result beat: hash %h row_end %0d",
                     $realtime, got.hash, got.row_end);
        end else begin
          want = expected_hashes.pop_front();
          if (got !== want) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("%t: mismatch: expected hash %h row_end %0d, got hash %h row_end %0d",
                       $realtime, want.hash, want.row_end, got.hash, got.row_end);
          end
        end
      end

      // Seed write restarts the chain and drops any open datum
      if (cfg_wr_en) begin
        seed_reg   = cfg_wr_data;
        chain_hash = cfg_wr_data;
        datum_open = 1'b0;
      end

      // Predict the column hash for an accepted input beat
      if (in_valid && in_ready) begin
        produced = 1'b1;
        col_hash = chain_hash;
        case (func_t'(in_func))
          FUNC_DATUM: begin
            col_hash = fnv_round(datum_open ? datum_hash : chain_hash, in_data_value[7:0]);
            if (!datum_open || in_data_value[7:0] != BLANK_BYTE)
              kept_hash = col_hash;
            datum_hash = col_hash;
            if (!in_last_of_datum) begin
              datum_open = 1'b1;
              produced   = 1'b0;
            end else if (in_trim_blanks) begin
              col_hash = kept_hash;
            end
          end
          FUNC_SCALAR: begin
            case (in_scalar_kind)
              KIND_BYTE: col_hash = fnv_bytes(chain_hash, in_data_value, CNT_ONE);
              KIND_WORD4, KIND_FLOAT4: begin
                word = {32'b0, in_data_value[31:0]};
                if (in_scalar_kind == KIND_FLOAT4 && word[31:0] == FLOAT4_NEG_ZERO)
                  word = '0;
                col_hash = fnv_bytes(chain_hash, word, CNT_FOUR);
              end
              default: begin
                // eight-byte kinds, unused kind codes included
                word = in_data_value;
                if (in_scalar_kind == KIND_FLOAT8 && word == FLOAT8_NEG_ZERO)
                  word = '0;
                col_hash = fnv_bytes(chain_hash, word, CNT_EIGHT);
              end
            endcase
          end
          FUNC_NULL: col_hash = fnv_bytes(chain_hash, {32'b0, NULL_WORD}, CNT_FOUR);
          default:   col_hash = chain_hash;
        endcase

        if (produced) begin
          datum_open = 1'b0;
          chain_hash = in_end_of_row ? seed_reg : col_hash;
          expected_hashes.push_back('{hash: col_hash, row_end: in_end_of_row});
        end
      end
    end

    mismatches   <= mismatch_total;
    pending      <= expected_hashes.size();
    results_seen <= result_total;
  end

endmodule

/* test/tb_chained_fnv1_column_hasher_core.sv */
`timescale 1ns / 100ps

module tb_chained_fnv1_column_hasher_core;
  import cfh_pkg::*;

  localparam int          CYCLE_LIMIT       = 600000;
  localparam int          HOLD_CYCLES       = 400;
  localparam int          SETTLE_CYCLES     = 16;
  localparam int          PHASE_ITEMS       = 220;
  localparam logic [2:0]  KIND_UNUSED_FIRST = 3'd5;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func          = '0;
  logic [63:0] in_data_value    = '0;
  logic [2:0]  in_scalar_kind   = '0;
  logic        in_last_of_datum = 1'b0;
  logic        in_trim_blanks   = 1'b0;
  logic        in_end_of_row    = 1'b0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [31:0] out_hash_value;
  logic        out_row_end;
  logic        cfg_wr_en        = 1'b0;
  logic [31:0] cfg_wr_data      = '0;

  int mismatches;
  int pending;
  int results_seen;

  int cycle_count   = 0;
  int items_sent    = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int rx_mode       = 0;
  int rx_left       = 0;
  int rx_period     = 2;
  int rx_tick       = 0;

  int n_bytes  = 0;
  int n_scalar = 0;
  int n_null   = 0;
  int n_empty  = 0;
  int n_rows   = 0;
  int n_seeds  = 0;

  chained_fnv1_column_hasher_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_data_value    (in_data_value),
    .in_scalar_kind   (in_scalar_kind),
    .in_last_of_datum (in_last_of_datum),
    .in_trim_blanks   (in_trim_blanks),
    .in_end_of_row    (in_end_of_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hash_value   (out_hash_value),
    .out_row_end      (out_row_end),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  fnv_column_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_data_value    (in_data_value),
    .in_scalar_kind   (in_scalar_kind),
    .in_last_of_datum (in_last_of_datum),
    .in_trim_blanks   (in_trim_blanks),
    .in_end_of_row    (in_end_of_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hash_value   (out_hash_value),
    .out_row_end      (out_row_end),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_seen     (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: long hold-offs on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
      if (hold_left == 0)
        hold_served++;
    end else if (hold_served != hold_requests) begin
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        rx_left   = $urandom_range(16, 128);
        rx_period = $urandom_range(2, 7);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_tick % rx_period) != 0;
      endcase
    end
  end

  // Offer one beat, hold it until accepted, then maybe idle for a while
  task automatic send_column(func_t f, logic [63:0] d, logic [2:0] k,
                             logic last, logic trim, logic eor);
    in_valid         <= 1'b1;
    in_func          <= f;
    in_data_value    <= d;
    in_scalar_kind   <= k;
    in_last_of_datum <= last;
    in_trim_blanks   <= trim;
    in_end_of_row    <= eor;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    case (f)
      FUNC_DATUM:  n_bytes++;
      FUNC_SCALAR: n_scalar++;
      FUNC_NULL:   n_null++;
      default:     n_empty++;
    endcase
    if (eor && (f != FUNC_DATUM || last))
      n_rows++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
    end
  endtask

  // Stop offering and wait until every predicted column hash has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the seed once the block is idle, leaving time for a trailing datum byte
  task automatic load_seed(logic [31:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_seeds++;
  endtask

  // Random rows under one seed; mostly well-formed, some datums left open
  task automatic run_phase(logic [31:0] seed, bit hold, bit pause);
    int          start;
    int          ncols;
    int          len;
    int          nblank;
    int          pick;
    logic [63:0] d;
    logic [2:0]  k;
    logic        trim;
    logic        last_b;
    logic        eor;
    bit          held;
    bit          paused;

    load_seed(seed);
    start  = items_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (items_sent - start < PHASE_ITEMS) begin
      if (hold && !held && items_sent - start >= 60) begin
        hold_requests <= hold_requests + 1;
        held = 1'b1;
      end
      if (pause && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      ncols = $urandom_range(1, 6);
      for (int c = 0; c < ncols; c++) begin
        eor  = (c == ncols - 1);
        pick = $urandom_range(0, 99);
        d    = {$urandom, $urandom};
        k    = 3'($urandom_range(0, 7));
        if (pick < 55) begin
          // datum; below 45 it is closed, otherwise left open
          len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
          nblank = ($urandom_range(0, 2) == 0) ? $urandom_range(1, len) : 0;
          trim   = 1'($urandom_range(0, 1));
          for (int i = 0; i < len; i++) begin
            last_b   = (i == len - 1) && (pick < 45);
            d        = {$urandom, $urandom};
            d[7:0]   = (i >= len - nblank) ? BLANK_BYTE : 8'($urandom_range(0, 255));
            send_column(FUNC_DATUM, d, 3'($urandom_range(0, 7)), last_b,
                        last_b ? trim : 1'($urandom_range(0, 1)),
                        last_b ? eor : 1'($urandom_range(0, 1)));
          end
        end else if (pick < 80) begin
          case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = '1;
            2:       d = FLOAT8_NEG_ZERO;
            3:       d[31:0] = FLOAT4_NEG_ZERO;
            default: ;
          endcase
          send_column(FUNC_SCALAR, d, k, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), eor);
        end else if (pick < 90) begin
          send_column(FUNC_NULL, d, k, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), eor);
        end else begin
          send_column(FUNC_EMPTY, d, k, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), eor);
        end
      end
    end
  endtask

  initial begin
    int u;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scalars at the field extremes, minus zero, unused kind codes
    send_column(FUNC_SCALAR, '1, KIND_BYTE, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_SCALAR, '1, KIND_WORD4, 1'b1, 1'b1, 1'b0);
    send_column(FUNC_SCALAR, '0, KIND_WORD8, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_SCALAR, {32'hDEAD_BEEF, FLOAT4_NEG_ZERO}, KIND_FLOAT4, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_SCALAR, FLOAT8_NEG_ZERO, KIND_FLOAT8, 1'b0, 1'b0, 1'b1);
    for (u = 0; u < 3; u++)
      send_column(FUNC_SCALAR, {$urandom, $urandom}, KIND_UNUSED_FIRST + 3'(u),
                  1'b0, 1'b0, u == 2);

    // Null and empty columns in one row that ends in two empties
    send_column(FUNC_NULL, '1, KIND_BYTE, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_EMPTY, '1, KIND_WORD8, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_EMPTY, '0, KIND_BYTE, 1'b0, 1'b0, 1'b1);

    // Trimmed datum; flags on inner bytes must be ignored
    send_column(FUNC_DATUM, 64'h61, KIND_BYTE, 1'b0, 1'b1, 1'b1);
    send_column(FUNC_DATUM, {56'hFF, BLANK_BYTE}, KIND_BYTE, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_DATUM, {56'h0, BLANK_BYTE}, KIND_BYTE, 1'b1, 1'b1, 1'b0);

    // All blanks with trim keeps the first byte
    send_column(FUNC_DATUM, {56'h0, BLANK_BYTE}, KIND_BYTE, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_DATUM, {56'h0, BLANK_BYTE}, KIND_BYTE, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_DATUM, {56'h0, BLANK_BYTE}, KIND_BYTE, 1'b1, 1'b1, 1'b1);

    // Single byte datum with high bits set; untrimmed trailing blank
    send_column(FUNC_DATUM, {56'hFF_FFFF_FFFF_FFFF, 8'h7E}, KIND_FLOAT8, 1'b1, 1'b0, 1'b0);
    send_column(FUNC_DATUM, 64'h78, KIND_BYTE, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_DATUM, {56'h0, BLANK_BYTE}, KIND_BYTE, 1'b1, 1'b0, 1'b0);

    // Open datum abandoned by a scalar that ends the row, then a null alone in a row
    send_column(FUNC_DATUM, 64'h71, KIND_BYTE, 1'b0, 1'b0, 1'b0);
    send_column(FUNC_SCALAR, 64'h0123_4567_89AB_CDEF, KIND_WORD4, 1'b0, 1'b0, 1'b1);
    send_column(FUNC_NULL, '0, KIND_BYTE, 1'b0, 1'b0, 1'b1);

    // Leave a datum open; the next seed write drops it
    send_column(FUNC_DATUM, 64'h7A, KIND_BYTE, 1'b0, 1'b0, 1'b0);

    run_phase(32'h0, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b1, 1'b0);
    run_phase($urandom, 1'b0, 1'b1);
    run_phase($urandom, 1'b1, 1'b0);
    run_phase(SEED_RESET, 1'b0, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d datum bytes, %0d scalars, %0d nulls, %0d empty columns in %0d rows.",
             n_bytes, n_scalar, n_null, n_empty, n_rows);
    $display("Checked %0d hashes across %0d seed loads and %0d long output stalls.",
             results_seen, n_seeds, hold_served);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* chained_fnv1_column_hasher_core.f */
design/cfh_pkg.sv
design/cfh_mix_unit.sv
design/chained_fnv1_column_hasher_core.sv
test/fnv_column_checker.sv
test/tb_chained_fnv1_column_hasher_core.sv
